### src/rgwc_pkg.sv
// ----------------------------------------------------------------------------
// rgwc_pkg
// Shared constants and types for the RTT gradient window controller.
// ----------------------------------------------------------------------------
package rgwc_pkg;

  localparam int unsigned RttW = 24;
  localparam int unsigned RateW = 32;
  localparam int unsigned DivW = 48;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [RttW-1:0] RttMax = 24'hFFFFFF;
  localparam logic [RateW-1:0] RateOne = 32'h0001_0000;

  localparam logic [CfgIdxW-1:0] RegEwmaGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDecGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLowThr = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHighThr = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBaseRtt = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIncStep = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBoost = 3'd6;
  localparam logic [CfgIdxW-1:0] RegStartWin = 3'd7;

  localparam logic [1:0] ActLowInc = 2'd0;
  localparam logic [1:0] ActHighDec = 2'd1;
  localparam logic [1:0] ActGradInc = 2'd2;
  localparam logic [1:0] ActGradDec = 2'd3;

  localparam int unsigned DefEwmaGain = 8192;
  localparam int unsigned DefDecGain = 26214;
  localparam int unsigned DefLowThr = 50;
  localparam int unsigned DefHighThr = 150;
  localparam int unsigned DefBaseRtt = 20;
  localparam int unsigned DefIncStep = 256;
  localparam int unsigned DefBoost = 5;
  localparam int unsigned DefStartWin = 10;

  typedef struct packed {
    logic load;
    logic ewma_a;
    logic ewma_b;
    logic classify;
    logic div_start;
    logic div_step;
    logic scale_a;
    logic scale_b;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

### src/rtt_gradient_window_control_top.sv
// ----------------------------------------------------------------------------
// rtt_gradient_window_control_top
// Delay-based congestion window controller driven by acknowledgement times.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry sent_time_ms_i and
//   ack_time_ms_i. One item is taken when valid is high and stall is low.
//   Output channel: out_valid_o / out_stall_i carry window_o, action_o and
//   measured_rtt_ms_o, one item per input item.
//   Config channel: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; write only while idle. Unknown indexes are ignored.
//   The 48-step restoring divider runs one quotient bit per cycle.
//   A new item is taken only after the previous one has been delivered.
//   Reset: config registers take their defaults, the window loads start_window.
//   A stalled output holds its item; the input stays stalled until taken.
// ----------------------------------------------------------------------------
module rtt_gradient_window_control_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] sent_time_ms_i,
  input  logic [63:0] ack_time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] window_o,
  output logic [1:0]  action_o,
  output logic [23:0] measured_rtt_ms_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  rgwc_pkg::cmd_t cmd;
  rgwc_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rgwc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  rgwc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sent_time_ms_i, .ack_time_ms_i,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .window_o, .action_o, .measured_rtt_ms_o
  );

endmodule

### src/rgwc_datapath.sv
// ----------------------------------------------------------------------------
// rgwc_datapath
// RTT, EWMA, rule selection, serial divider and rate scaling.
// ----------------------------------------------------------------------------
module rgwc_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rgwc_pkg::cmd_t              cmd_i,
  output rgwc_pkg::sts_t              sts_o,
  input  logic [63:0]                 sent_time_ms_i,
  input  logic [63:0]                 ack_time_ms_i,
  input  logic                        cfg_we_i,
  input  logic [rgwc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_data_i,
  output logic [15:0]                 window_o,
  output logic [1:0]                  action_o,
  output logic [rgwc_pkg::RttW-1:0]   measured_rtt_ms_o
);

  logic [15:0] ewma_gain_q, dec_gain_q, low_thr_q, high_thr_q, base_rtt_q, inc_step_q;
  logic [15:0] start_win_q;
  logic [3:0]  boost_q;
  logic [31:0] rate_q, rate_d;
  logic [23:0] last_rtt_q, rtt_q;
  logic signed [31:0] avg_q, diff_q;
  logic signed [49:0] acc_q;
  logic signed [49:0] acc_sum;
  logic [1:0]  act_q;
  logic [63:0] d_full;
  logic [24:0] diff_raw;
  logic signed [34:0] diff_w;
  logic [47:0] num_q, quo_q;
  logic [24:0] den_q;
  logic [25:0] rem_q;
  logic [25:0] rem_sh;
  logic [5:0]  cnt_q;
  logic [31:0] prod_q;
  logic [16:0] sub_q;
  logic [48:0] mul_q;
  logic        sat_one_q;
  logic [15:0] start_eff;
  logic [33:0] add_sum;
  logic [19:0] inc_b;

  assign d_full = ack_time_ms_i - sent_time_ms_i;
  assign diff_raw = {1'b0, rtt_q} - {1'b0, last_rtt_q};
  assign diff_w = {{2{diff_raw[24]}}, diff_raw, 8'h00};
  assign start_eff = (start_win_q == 16'd0) ? 16'd1 : start_win_q;
  assign inc_b = 20'(boost_q) * 20'(inc_step_q);
  assign rem_sh = {rem_q[24:0], num_q[47]};
  assign acc_sum = acc_q + $signed({1'b0, ewma_gain_q}) * diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ewma_gain_q <= 16'(rgwc_pkg::DefEwmaGain);
      dec_gain_q <= 16'(rgwc_pkg::DefDecGain);
      low_thr_q <= 16'(rgwc_pkg::DefLowThr);
      high_thr_q <= 16'(rgwc_pkg::DefHighThr);
      base_rtt_q <= 16'(rgwc_pkg::DefBaseRtt);
      inc_step_q <= 16'(rgwc_pkg::DefIncStep);
      boost_q <= 4'(rgwc_pkg::DefBoost);
      start_win_q <= 16'(rgwc_pkg::DefStartWin);
      rate_q <= {16'(rgwc_pkg::DefStartWin), 16'h0};
      last_rtt_q <= '0;
      avg_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rgwc_pkg::RegEwmaGain: ewma_gain_q <= cfg_data_i;
          rgwc_pkg::RegDecGain: dec_gain_q <= cfg_data_i;
          rgwc_pkg::RegLowThr: low_thr_q <= cfg_data_i;
          rgwc_pkg::RegHighThr: high_thr_q <= cfg_data_i;
          rgwc_pkg::RegBaseRtt: base_rtt_q <= cfg_data_i;
          rgwc_pkg::RegIncStep: inc_step_q <= cfg_data_i;
          rgwc_pkg::RegBoost: boost_q <= cfg_data_i[3:0];
          rgwc_pkg::RegStartWin: begin
            start_win_q <= cfg_data_i;
            rate_q <= {((cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i), 16'h0};
          end
          default: ;
        endcase
      end
      if (cmd_i.ewma_b) begin
        avg_q <= 32'(acc_sum >>> 16);
        last_rtt_q <= rtt_q;
      end
      if (cmd_i.finish) rate_q <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) rtt_q <= (d_full > 64'(rgwc_pkg::RttMax)) ? rgwc_pkg::RttMax : d_full[23:0];
    if (cmd_i.ewma_a) begin
      if (diff_w > 35'sh7FFFFFFF) diff_q <= 32'h7FFFFFFF;
      else if (diff_w < -35'sh80000000) diff_q <= 32'h80000000;
      else diff_q <= diff_w[31:0];
      acc_q <= $signed({1'b0, 17'(17'h10000 - 17'(ewma_gain_q))}) * avg_q;
    end
    if (cmd_i.classify) begin
      if (rtt_q < 24'(low_thr_q)) act_q <= rgwc_pkg::ActLowInc;
      else if (rtt_q > 24'(high_thr_q)) act_q <= rgwc_pkg::ActHighDec;
      else if (avg_q <= 0) act_q <= rgwc_pkg::ActGradInc;
      else act_q <= rgwc_pkg::ActGradDec;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      cnt_q <= '0;
      if (act_q == rgwc_pkg::ActHighDec) begin
        num_q <= {16'h0, high_thr_q, 16'h0};
        den_q <= {1'b0, rtt_q};
      end else begin
        prod_q <= 32'(avg_q);
        num_q <= 48'(dec_gain_q) * 48'(avg_q);
        den_q <= {1'b0, ((base_rtt_q == 16'd0) ? 16'd1 : base_rtt_q), 8'h00};
      end
    end
    if (cmd_i.div_step) begin
      num_q <= {num_q[46:0], 1'b0};
      cnt_q <= cnt_q + 6'd1;
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
    if (cmd_i.scale_a) begin
      if (act_q == rgwc_pkg::ActHighDec) begin
        sub_q <= 17'((33'(dec_gain_q) * 33'(17'h10000 - quo_q[16:0])) >> 16);
        sat_one_q <= 1'b0;
      end else begin
        sat_one_q <= (quo_q >= 48'h10000);
        sub_q <= (quo_q >= 48'h10000) ? 17'h10000 : quo_q[16:0];
      end
    end
    if (cmd_i.scale_b) mul_q <= 49'(rate_q) * 49'(17'h10000 - sub_q);
  end

  always_comb begin
    add_sum = '0;
    rate_d = rate_q;
    unique case (act_q)
      rgwc_pkg::ActLowInc: add_sum = 34'(rate_q) + 34'({inc_step_q, 8'h00});
      rgwc_pkg::ActGradInc: add_sum = 34'(rate_q) + 34'({inc_b, 8'h00});
      default: add_sum = (sat_one_q || sub_q[16]) ? 34'(rgwc_pkg::RateOne) : 34'(mul_q >> 16);
    endcase
    if (add_sum > 34'hFFFFFFFF) rate_d = 32'hFFFFFFFF;
    else if (add_sum < 34'(rgwc_pkg::RateOne)) rate_d = rgwc_pkg::RateOne;
    else rate_d = add_sum[31:0];
  end

  assign sts_o.div_done = (cnt_q == 6'(rgwc_pkg::DivW - 1)) && cmd_i.div_step;
  assign window_o = rate_q[31:16];
  assign action_o = act_q;
  assign measured_rtt_ms_o = rtt_q;

  logic unused_w;
  assign unused_w = ^{prod_q, start_eff, rgwc_pkg::DivCntW};

endmodule

### src/rgwc_ctrl.sv
// ----------------------------------------------------------------------------
// rgwc_ctrl
// Sequencer for one item: load, EWMA, classify, divide, scale, deliver.
// ----------------------------------------------------------------------------
module rgwc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rgwc_pkg::cmd_t cmd_o,
  input  rgwc_pkg::sts_t sts_i
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SEwmaA = 4'd1;
  localparam logic [3:0] SEwmaB = 4'd2;
  localparam logic [3:0] SClass = 4'd3;
  localparam logic [3:0] SDivSt = 4'd4;
  localparam logic [3:0] SDiv = 4'd5;
  localparam logic [3:0] SScaleA = 4'd6;
  localparam logic [3:0] SScaleB = 4'd7;
  localparam logic [3:0] SFinish = 4'd8;
  localparam logic [3:0] SOut = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    cmd_o = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d = SEwmaA;
      end
      SEwmaA: begin
        cmd_o.ewma_a = 1'b1;
        state_d = SEwmaB;
      end
      SEwmaB: begin
        cmd_o.ewma_b = 1'b1;
        state_d = SClass;
      end
      SClass: begin
        cmd_o.classify = 1'b1;
        state_d = SDivSt;
      end
      SDivSt: begin
        cmd_o.div_start = 1'b1;
        state_d = SDiv;
      end
      SDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) state_d = SScaleA;
      end
      SScaleA: begin
        cmd_o.scale_a = 1'b1;
        state_d = SScaleB;
      end
      SScaleB: begin
        cmd_o.scale_b = 1'b1;
        state_d = SFinish;
      end
      SFinish: begin
        cmd_o.finish = 1'b1;
        state_d = SOut;
      end
      SOut: if (!out_stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

endmodule
